FILE: hdl/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

    // Fixed field widths of the item ports
    localparam int COORD_W   = 14;
    localparam int IDX_W     = 12;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Item kinds
    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    // Neighbor read request from the address stage
    typedef struct packed {
        logic valid;
        logic dx;
    } t_rd_ctl;

    // The four neighbors, {r, g, b} each
    typedef struct packed {
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p11;
    } t_quad;

endpackage

FILE: hdl/bps_addr.sv
`timescale 1ns / 1ps

module bps_addr
    import bps_pkg::*;
#(
    parameter int MAX_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic                              i_req_type,
    input  logic [IDX_W-1:0]                  i_pixel_index,
    input  logic [PIX_W-1:0]                  i_pixel,
    input  logic [COORD_W-1:0]                i_sample_x,
    input  logic [COORD_W-1:0]                i_sample_y,
    input  logic [$clog2(MAX_SIDE+1)-1:0]     i_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0]     i_height,
    output logic                              o_we,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] o_waddr,
    output logic [PIX_W-1:0]                  o_wdata,
    output t_rd_ctl                           o_rd,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] o_a,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] o_b,
    output logic [FRAC_BITS-1:0]              o_fx,
    output logic [FRAC_BITS-1:0]              o_fy
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int INT_W  = COORD_W - FRAC_BITS;
    localparam int CLP_W  = (INT_W > SIDE_W) ? INT_W : SIDE_W;
    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int AREA_W = 2 * SIDE_W;
    localparam int CMP_W  = (AREA_W > IDX_W) ? AREA_W : IDX_W;

    // Input stage
    logic                 r_v1;
    logic                 r_type1;
    logic [IDX_W-1:0]     r_idx1;
    logic [PIX_W-1:0]     r_pix1;
    logic [COORD_W-1:0]   r_sx1;
    logic [COORD_W-1:0]   r_sy1;

    // Address stage
    logic                 r_we2;
    logic [ADDR_W-1:0]    r_waddr2;
    logic [PIX_W-1:0]     r_wdata2;
    logic                 r_rv2;
    logic                 r_dx2;
    logic [ADDR_W-1:0]    r_a2;
    logic [ADDR_W-1:0]    r_b2;
    logic [FRAC_BITS-1:0] r_fx2;
    logic [FRAC_BITS-1:0] r_fy2;

    logic [INT_W-1:0]     x_int;
    logic [INT_W-1:0]     y_int;
    logic [SIDE_W-1:0]    wm1;
    logic [SIDE_W-1:0]    hm1;
    logic [SIDE_W-1:0]    x0;
    logic [SIDE_W-1:0]    y0;
    logic                 dx;
    logic                 dy;
    logic [AREA_W-1:0]    lin;
    logic [AREA_W-1:0]    area;
    logic [ADDR_W-1:0]    a;
    logic [ADDR_W-1:0]    b;
    logic                 wr_ok;
    logic                 is_write;
    logic                 is_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_type1 <= i_req_type;
            r_idx1  <= i_pixel_index;
            r_pix1  <= i_pixel;
            r_sx1   <= i_sample_x;
            r_sy1   <= i_sample_y;
        end
    end

    // Clamp the top-left neighbor into the image, then step right and down
    // unless already on the last column or row.
    always_comb begin
        x_int = r_sx1[COORD_W-1:FRAC_BITS];
        y_int = r_sy1[COORD_W-1:FRAC_BITS];
        wm1   = i_width - SIDE_W'(1);
        hm1   = i_height - SIDE_W'(1);
        x0    = (CLP_W'(x_int) > CLP_W'(wm1)) ? wm1 : SIDE_W'(x_int);
        y0    = (CLP_W'(y_int) > CLP_W'(hm1)) ? hm1 : SIDE_W'(y_int);
        dx    = (x0 != wm1);
        dy    = (y0 != hm1);
        lin   = AREA_W'(y0) * AREA_W'(i_width) + AREA_W'(x0);
        a     = ADDR_W'(lin);
        b     = a + (dy ? ADDR_W'(i_width) : '0);
    end

    // Writes outside width * height are dropped
    always_comb begin
        area      = AREA_W'(i_width) * AREA_W'(i_height);
        wr_ok     = CMP_W'(r_idx1) < CMP_W'(area);
        is_write  = r_v1 && (r_type1 == REQ_WRITE);
        is_sample = r_v1 && (r_type1 == REQ_SAMPLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we2 <= 1'b0;
            r_rv2 <= 1'b0;
        end else begin
            r_we2 <= is_write && wr_ok;
            r_rv2 <= is_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr2 <= ADDR_W'(CMP_W'(r_idx1));
        r_wdata2 <= r_pix1;
        r_dx2    <= dx;
        r_a2     <= a;
        r_b2     <= b;
        r_fx2    <= r_sx1[FRAC_BITS-1:0];
        r_fy2    <= r_sy1[FRAC_BITS-1:0];
    end

    assign o_we     = r_we2;
    assign o_waddr  = r_waddr2;
    assign o_wdata  = r_wdata2;
    assign o_rd     = '{valid: r_rv2, dx: r_dx2};
    assign o_a      = r_a2;
    assign o_b      = r_b2;
    assign o_fx     = r_fx2;
    assign o_fy     = r_fy2;

endmodule

FILE: hdl/bps_store.sv
`timescale 1ns / 1ps

module bps_store
    import bps_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    output logic                                 o_busy,
    input  logic                                 i_we,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] i_waddr,
    input  logic [PIX_W-1:0]                     i_wdata,
    input  t_rd_ctl                              i_rd,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] i_a,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] i_b,
    output logic                                 o_rd_valid,
    output t_quad                                o_quad
);

    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int BANK_DEPTH = (DEPTH + 1) / 2;
    localparam int BA_W       = ADDR_W - 1;

    // Clearing pass after reset
    logic            r_busy;
    logic [BA_W-1:0] r_clr_addr;

    // Read side control, aligned with the bank outputs
    logic r_rd_valid;
    logic r_dx;
    logic r_a_odd;
    logic r_b_odd;

    logic [PIX_W-1:0] bank_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd.valid;
            if (r_busy) begin
                r_clr_addr <= r_clr_addr + BA_W'(1);
                if (r_clr_addr == BA_W'(BANK_DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= i_rd.dx;
        r_a_odd <= i_a[0];
        r_b_odd <= i_b[0];
    end

    // Two copies (row y0 and row y1), each split into even and odd index
    // banks, so a pixel and its right neighbor sit in different banks.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        localparam bit IS_ODD = bit'(g % 2);
        localparam bit IS_B   = bit'(g / 2);

        logic [PIX_W-1:0]  r_mem [BANK_DEPTH];
        logic [PIX_W-1:0]  r_q;
        logic [ADDR_W-1:0] base;
        logic [BA_W-1:0]   half;
        logic [BA_W-1:0]   raddr;
        logic              we;
        logic [BA_W-1:0]   waddr;
        logic [PIX_W-1:0]  wdata;

        always_comb begin
            base  = IS_B ? i_b : i_a;
            half  = base[ADDR_W-1:1];
            raddr = (!IS_ODD && base[0]) ? half + BA_W'(1) : half;
            we    = r_busy || (i_we && (i_waddr[0] == IS_ODD));
            waddr = r_busy ? r_clr_addr : i_waddr[ADDR_W-1:1];
            wdata = r_busy ? '0 : i_wdata;
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[waddr] <= wdata;
            end
        end

        always_ff @(posedge i_clk) begin
            r_q <= r_mem[raddr];
        end

        assign bank_q[g] = r_q;
    end

    // Pick each neighbor from its bank; without a right step both columns
    // come from the same entry.
    always_comb begin
        o_quad.p00 = r_a_odd ? bank_q[1] : bank_q[0];
        o_quad.p10 = r_dx ? (r_a_odd ? bank_q[0] : bank_q[1])
                          : (r_a_odd ? bank_q[1] : bank_q[0]);
        o_quad.p01 = r_b_odd ? bank_q[3] : bank_q[2];
        o_quad.p11 = r_dx ? (r_b_odd ? bank_q[2] : bank_q[3])
                          : (r_b_odd ? bank_q[3] : bank_q[2]);
    end

    assign o_busy     = r_busy;
    assign o_rd_valid = r_rd_valid;

endmodule

FILE: hdl/bps_blend.sv
`timescale 1ns / 1ps

module bps_blend
    import bps_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    input  logic                 i_rd_valid,
    input  t_quad                i_quad,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_pixel
);

    localparam int unsigned ONE = 1 << FRAC_BITS;
    localparam int OW    = FRAC_BITS + 1;
    localparam int WW    = 2 * FRAC_BITS + 2;
    localparam int SUM_W = CH_W + 2 * FRAC_BITS;

    // Fractions, aligned with the bank outputs
    logic [FRAC_BITS-1:0] r_fx3;
    logic [FRAC_BITS-1:0] r_fy3;

    // Weight stage
    logic          r_v4;
    t_quad         r_q4;
    logic [WW-1:0] r_w00;
    logic [WW-1:0] r_w10;
    logic [WW-1:0] r_w01;
    logic [WW-1:0] r_w11;

    // Result stage
    logic             r_v5;
    logic [PIX_W-1:0] r_pix5;

    logic [OW-1:0]    omfx;
    logic [OW-1:0]    omfy;
    logic [WW-1:0]    n_w00;
    logic [WW-1:0]    n_w10;
    logic [WW-1:0]    n_w01;
    logic [WW-1:0]    n_w11;
    logic [PIX_W-1:0] n_pix;

    always_ff @(posedge i_clk) begin
        r_fx3 <= i_fx;
        r_fy3 <= i_fy;
    end

    // Bilinear weights, they sum to ONE * ONE
    always_comb begin
        omfx  = OW'(ONE) - OW'(r_fx3);
        omfy  = OW'(ONE) - OW'(r_fy3);
        n_w00 = WW'(omfx) * WW'(omfy);
        n_w10 = WW'(r_fx3) * WW'(omfy);
        n_w01 = WW'(omfx) * WW'(r_fy3);
        n_w11 = WW'(r_fx3) * WW'(r_fy3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_rd_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q4  <= i_quad;
        r_w00 <= n_w00;
        r_w10 <= n_w10;
        r_w01 <= n_w01;
        r_w11 <= n_w11;
    end

    // Weighted sum per channel, truncated
    always_comb begin
        logic [SUM_W-1:0] sum;
        int               hi;
        n_pix = '0;
        for (int c = 0; c < 3; c++) begin
            hi  = PIX_W - 1 - CH_W * c;
            sum = SUM_W'(r_q4.p00[hi -: CH_W]) * SUM_W'(r_w00)
                + SUM_W'(r_q4.p10[hi -: CH_W]) * SUM_W'(r_w10)
                + SUM_W'(r_q4.p01[hi -: CH_W]) * SUM_W'(r_w01)
                + SUM_W'(r_q4.p11[hi -: CH_W]) * SUM_W'(r_w11);
            n_pix[hi -: CH_W] = sum[SUM_W-1 -: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix5 <= n_pix;
    end

    assign o_valid = r_v5;
    assign o_pixel = r_pix5;

endmodule

FILE: hdl/bps_out_fifo.sv
`timescale 1ns / 1ps

module bps_out_fifo
    import bps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [PIX_W-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_data
);

    logic [PIX_W-1:0]     r_entry [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop;

    // Upstream never pushes into a full queue: its credit count sees to that
    assign pop = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];

endmodule

FILE: hdl/bilinear_pixel_sampler.sv
`timescale 1ns / 1ps

// Bilinear RGB888 sampler over a MAX_SIDE x MAX_SIDE pixel store. Write items
// store a pixel at a row-major index (ignored past width * height); sample
// items return one interpolated pixel through the input, address, store read,
// weight and result registers and the output queue. One item is taken per
// clock while o_stall is low: the store is kept as two copies, each split into
// even and odd index banks, so the four neighbors of a sample are read in the
// same cycle. After reset the store is cleared to black with o_stall high;
// configuration writes are taken during it. Up to 8 samples may be in flight
// or queued at the output; input stalls when all 8 slots are taken.
module bilinear_pixel_sampler
    import bps_pkg::*;
#(
    parameter int MAX_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [IDX_W-1:0]     i_pixel_index,
    input  logic [CH_W-1:0]      i_red_in,
    input  logic [CH_W-1:0]      i_green_in,
    input  logic [CH_W-1:0]      i_blue_in,
    input  logic [COORD_W-1:0]   i_sample_x,
    input  logic [COORD_W-1:0]   i_sample_y,
    // Result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CH_W-1:0]      o_red_out,
    output logic [CH_W-1:0]      o_green_out,
    output logic [CH_W-1:0]      o_blue_out,
    // Configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CFG_CMP_W  = (CFG_W > SIDE_W) ? CFG_W : SIDE_W;
    localparam int RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

    // Effective image size, already clamped into 1..MAX_SIDE
    logic [SIDE_W-1:0]    r_width;
    logic [SIDE_W-1:0]    r_height;
    logic [SIDE_W-1:0]    cfg_side;

    logic [OUT_CNT_W-1:0] r_inflight;
    logic                 in_acc;
    logic                 out_acc;
    logic                 smp_acc;
    logic                 busy;

    logic                 st_we;
    logic [ADDR_W-1:0]    st_waddr;
    logic [PIX_W-1:0]     st_wdata;
    t_rd_ctl              st_rd;
    logic [ADDR_W-1:0]    st_a;
    logic [ADDR_W-1:0]    st_b;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 rd_valid;
    t_quad                quad;
    logic                 res_valid;
    logic [PIX_W-1:0]     res_pixel;
    logic [PIX_W-1:0]     out_pixel;

    // Configuration writes
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_side = SIDE_W'(1);
        end else if (CFG_CMP_W'(i_cfg_data) > CFG_CMP_W'(MAX_SIDE)) begin
            cfg_side = SIDE_W'(MAX_SIDE);
        end else begin
            cfg_side = SIDE_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(RESET_SIDE);
            r_height <= SIDE_W'(RESET_SIDE);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= cfg_side;
                CFG_IMAGE_HEIGHT: r_height <= cfg_side;
                default:          ;
            endcase
        end
    end

    // Credit count: samples accepted whose results are not yet taken
    assign in_acc  = i_valid && !o_stall;
    assign smp_acc = in_acc && (i_req_type == REQ_SAMPLE);
    assign out_acc = o_valid && !i_stall;
    assign o_stall = busy || (r_inflight == OUT_CNT_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + OUT_CNT_W'(smp_acc) - OUT_CNT_W'(out_acc);
        end
    end

    bps_addr #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_req_type    (i_req_type),
        .i_pixel_index (i_pixel_index),
        .i_pixel       ({i_red_in, i_green_in, i_blue_in}),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_we          (st_we),
        .o_waddr       (st_waddr),
        .o_wdata       (st_wdata),
        .o_rd          (st_rd),
        .o_a           (st_a),
        .o_b           (st_b),
        .o_fx          (fx),
        .o_fy          (fy)
    );

    bps_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_busy     (busy),
        .i_we       (st_we),
        .i_waddr    (st_waddr),
        .i_wdata    (st_wdata),
        .i_rd       (st_rd),
        .i_a        (st_a),
        .i_b        (st_b),
        .o_rd_valid (rd_valid),
        .o_quad     (quad)
    );

    bps_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fx       (fx),
        .i_fy       (fy),
        .i_rd_valid (rd_valid),
        .i_quad     (quad),
        .o_valid    (res_valid),
        .o_pixel    (res_pixel)
    );

    bps_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_pixel)
    );

    assign o_red_out   = out_pixel[PIX_W-1 -: CH_W];
    assign o_green_out = out_pixel[PIX_W-1-CH_W -: CH_W];
    assign o_blue_out  = out_pixel[CH_W-1:0];

endmodule

FILE: hdl/bps_checker.sv
`timescale 1ns / 1ps

module bps_checker
    import bps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic                 i_req_type,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [CH_W-1:0]      o_red_out,
    input  logic [CH_W-1:0]      o_green_out,
    input  logic [CH_W-1:0]      o_blue_out
);

    logic smp_acc;

    assign smp_acc = i_valid && !o_stall && (i_req_type == REQ_SAMPLE);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending right after reset");

    // Store clearing holds off items right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("item input open during store clear");

    // A result appearing on an empty output comes from an accepted sample item
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(smp_acc, 6))
        else $error("result without a matching sample item");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out))
        else $error("stalled result changed");

endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (.*);

FILE: verif/bilinear_pixel_sampler_tb.sv
`timescale 1ns / 1ps

module bilinear_pixel_sampler_tb;
    import bps_pkg::*;

    localparam int MAX_SIDE     = 64;
    localparam int FRAC_BITS    = 8;
    localparam int FRAC_ONE     = 1 << FRAC_BITS;
    localparam int INT_W        = COORD_W - FRAC_BITS;
    localparam int ITEMS_TOTAL  = 1650;
    localparam int NUM_PHASES   = 10;
    localparam int PRESS_ITEMS  = 40;
    localparam int HOLDOFF_CYC  = 200;
    localparam int SETTLE_CYC   = 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        t_req               req;
        logic [IDX_W-1:0]   idx;
        t_rgb               px;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
    } t_pix_item;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_pix_item        item;
        bit               has_exp;
        t_rgb             exp_px;
        t_cfg_idx         reg_idx;
        logic [CFG_W-1:0] reg_val;
    } t_dir_row;

    // Clock, reset and block ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_req_type    = REQ_WRITE;
    logic [IDX_W-1:0]     i_pixel_index = '0;
    logic [CH_W-1:0]      i_red_in      = '0;
    logic [CH_W-1:0]      i_green_in    = '0;
    logic [CH_W-1:0]      i_blue_in     = '0;
    logic [COORD_W-1:0]   i_sample_x    = '0;
    logic [COORD_W-1:0]   i_sample_y    = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [CH_W-1:0]      o_red_out;
    logic [CH_W-1:0]      o_green_out;
    logic [CH_W-1:0]      o_blue_out;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // Predictor state: image copy and the two size registers
    logic [PIX_W-1:0] image_mem [MAX_SIDE*MAX_SIDE];
    logic [CFG_W-1:0] img_w_reg = 7'd64;
    logic [CFG_W-1:0] img_h_reg = 7'd64;

    t_rgb     pending_px[$];
    t_dir_row dir_rows[$];
    int       err_cnt     = 0;
    int       cycle_cnt   = 0;
    int       idle_pct    = 22;
    int       stall_pct   = 22;
    logic     holdoff_req = 1'b0;

    bilinear_pixel_sampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_pixel_index (i_pixel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Size in use: zero acts as one, anything past the store side as the side
    function automatic int unsigned used_side(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    // Bilinear blend of the four neighbors, edge clamped, truncated per channel
    function automatic t_rgb bilinear_rgb(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
        int unsigned      w, h, fx, fy, x0, y0, x1, y1, sum, sh;
        int unsigned      wt [4];
        logic [PIX_W-1:0] nb [4];
        logic [PIX_W-1:0] acc;
        w  = used_side(img_w_reg);
        h  = used_side(img_h_reg);
        fx = sx & (FRAC_ONE - 1);
        fy = sy & (FRAC_ONE - 1);
        x0 = sx >> FRAC_BITS;
        y0 = sy >> FRAC_BITS;
        if (x0 > w - 1) x0 = w - 1;
        if (y0 > h - 1) y0 = h - 1;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        nb[0] = image_mem[y0*w + x0];
        nb[1] = image_mem[y0*w + x1];
        nb[2] = image_mem[y1*w + x0];
        nb[3] = image_mem[y1*w + x1];
        wt[0] = (FRAC_ONE - fx) * (FRAC_ONE - fy);
        wt[1] = fx * (FRAC_ONE - fy);
        wt[2] = (FRAC_ONE - fx) * fy;
        wt[3] = fx * fy;
        for (int c = 0; c < 3; c++) begin
            sh  = 16 - 8*c;
            sum = 0;
            for (int k = 0; k < 4; k++) sum += ((nb[k] >> sh) & 8'hFF) * wt[k];
            acc[sh +: 8] = CH_W'(sum >> (2*FRAC_BITS));
        end
        return t_rgb'(acc);
    endfunction

    // Directed table rows
    function automatic t_dir_row row_wr(int idx, t_rgb px);
        t_dir_row row;
        row = '{ROW_ITEM, '0, 1'b0, '0, CFG_IMAGE_WIDTH, '0};
        row.item.req = REQ_WRITE;
        row.item.idx = IDX_W'(idx);
        row.item.px  = px;
        return row;
    endfunction

    function automatic t_dir_row row_smp(int sx, int sy);
        t_dir_row row;
        row = '{ROW_ITEM, '0, 1'b0, '0, CFG_IMAGE_WIDTH, '0};
        row.item.req = REQ_SAMPLE;
        row.item.sx  = COORD_W'(sx);
        row.item.sy  = COORD_W'(sy);
        return row;
    endfunction

    function automatic t_dir_row row_smp_exp(int sx, int sy, t_rgb px);
        t_dir_row row;
        row = row_smp(sx, sy);
        row.has_exp = 1'b1;
        row.exp_px  = px;
        return row;
    endfunction

    function automatic t_dir_row row_cfg(t_cfg_idx idx, int val);
        t_dir_row row;
        row = '{ROW_CFG, '0, 1'b0, '0, idx, CFG_W'(val)};
        return row;
    endfunction

    // Random item: mostly writes inside the image and samples over it,
    // some raw values anywhere in the field ranges
    function automatic t_pix_item rand_item();
        t_pix_item            it;
        int unsigned          w, h, roll;
        logic [INT_W-1:0]     ix, iy;
        logic [FRAC_BITS-1:0] fx, fy;
        w       = used_side(img_w_reg);
        h       = used_side(img_h_reg);
        it.req  = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_SAMPLE;
        it.px   = {8'($urandom), 8'($urandom), 8'($urandom)};
        it.idx  = IDX_W'(($urandom_range(99) < 88) ? $urandom_range(w*h - 1)
                                                   : $urandom_range(4095));
        roll    = $urandom_range(99);
        ix      = INT_W'((roll < 80) ? $urandom_range(w - 1) : $urandom_range(63));
        iy      = INT_W'((roll < 80) ? $urandom_range(h - 1) : $urandom_range(63));
        roll    = $urandom_range(99);
        fx      = (roll < 10) ? '0 : (roll < 20) ? '1 : FRAC_BITS'($urandom);
        roll    = $urandom_range(99);
        fy      = (roll < 10) ? '0 : (roll < 20) ? '1 : FRAC_BITS'($urandom);
        it.sx   = {ix, fx};
        it.sy   = {iy, fy};
        if ($urandom_range(99) < 5) begin
            it.sx = COORD_W'($urandom_range(16383));
            it.sy = COORD_W'($urandom_range(16383));
        end
        return it;
    endfunction

    // Offer one item, hold it until taken, then update the image copy or
    // queue the expected pixel. Returns whether the item has any effect.
    task automatic feed_item(input t_pix_item it, input bit has_exp, input t_rgb fixed_px,
                             output bit effective);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= it.req;
        i_pixel_index <= it.idx;
        i_red_in      <= it.px.r;
        i_green_in    <= it.px.g;
        i_blue_in     <= it.px.b;
        i_sample_x    <= it.sx;
        i_sample_y    <= it.sy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        effective = 1'b1;
        if (it.req == REQ_WRITE) begin
            if (it.idx < used_side(img_w_reg) * used_side(img_h_reg))
                image_mem[it.idx] = it.px;
            else
                effective = 1'b0;
        end else begin
            pending_px.push_back(has_exp ? fixed_px : bilinear_rgb(it.sx, it.sy));
        end
    endtask

    // Stop offering, wait for every pending pixel, then let trailing writes land
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  img_w_reg = val;
            CFG_IMAGE_HEIGHT: img_h_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cmp_chan(input string name, input logic [CH_W-1:0] want,
                            input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_rgb want_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_px.size() == 0) begin
                $error("result with no sample pending: %0h %0h %0h",
                       o_red_out, o_green_out, o_blue_out);
                err_cnt++;
            end else begin
                want_px = pending_px.pop_front();
                cmp_chan("red_out", want_px.r, o_red_out);
                cmp_chan("green_out", want_px.g, o_green_out);
                cmp_chan("blue_out", want_px.b, o_blue_out);
            end
        end
    end

    // Receiver stalls: random, none, or one long hold-off on request
    initial begin : rx_stall
        bit holdoff_done;
        holdoff_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req && !holdoff_done) begin
                holdoff_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYC) @(posedge i_clk);
            end
            i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Stimulus
    initial begin : stim
        logic [CFG_W-1:0] ph_w [NUM_PHASES];
        logic [CFG_W-1:0] ph_h [NUM_PHASES];
        t_pix_item        it;
        bit               took;
        int               fed;
        ph_w = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd1, 7'd0, 7'd0, 7'd64, 7'd0};
        ph_h = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd1, 7'd64, 7'd0, 7'd0, 7'd64, 7'd0};
        foreach (image_mem[i]) image_mem[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: black after reset, extremes, edge clamps, ignored writes,
        // out-of-range size registers
        dir_rows.push_back(row_smp_exp(14'h0000, 14'h0000, 24'h000000));
        dir_rows.push_back(row_smp_exp(14'h3FFF, 14'h3FFF, 24'h000000));
        dir_rows.push_back(row_wr(0, 24'hFFFFFF));
        dir_rows.push_back(row_wr(4095, 24'hA55A00));
        dir_rows.push_back(row_smp_exp(14'h0000, 14'h0000, 24'hFFFFFF));
        dir_rows.push_back(row_smp_exp(14'h3FFF, 14'h3FFF, 24'hA55A00));
        dir_rows.push_back(row_wr(1, 24'h0080FF));
        dir_rows.push_back(row_smp(14'h0080, 14'h0000));
        dir_rows.push_back(row_smp(14'h00FF, 14'h00FF));
        dir_rows.push_back(row_wr(64, 24'h123456));
        dir_rows.push_back(row_smp(14'h3EFF, 14'h00FF));
        dir_rows.push_back(row_cfg(CFG_IMAGE_WIDTH, 0));
        dir_rows.push_back(row_cfg(CFG_IMAGE_HEIGHT, 127));
        dir_rows.push_back(row_wr(63, 24'h778899));
        dir_rows.push_back(row_wr(64, 24'h112233));
        dir_rows.push_back(row_smp_exp(14'h3FFF, 14'h3F80, 24'h778899));
        dir_rows.push_back(row_cfg(CFG_IMAGE_WIDTH, 65));
        dir_rows.push_back(row_cfg(CFG_IMAGE_HEIGHT, 64));
        dir_rows.push_back(row_smp_exp(14'h0000, 14'h0100, 24'h123456));
        dir_rows.push_back(row_cfg(CFG_IMAGE_WIDTH, 7));
        dir_rows.push_back(row_cfg(CFG_IMAGE_HEIGHT, 5));
        dir_rows.push_back(row_wr(34, 24'hFF00FF));
        dir_rows.push_back(row_wr(35, 24'h010203));
        dir_rows.push_back(row_smp_exp(14'h3FFF, 14'h3FFF, 24'hFF00FF));
        dir_rows.push_back(row_smp(14'h0280, 14'h0340));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                feed_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp_px, took);
            end
        end

        // Random phases, one size setting each; zeros random outside phases 2, 3
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, (ph_w[ph] != 0 || ph == 2) ? ph_w[ph]
                                                                  : 7'($urandom_range(1, 64)));
            write_reg(CFG_IMAGE_HEIGHT, (ph_h[ph] != 0 || ph == 3) ? ph_h[ph]
                                                                   : 7'($urandom_range(1, 64)));
            idle_pct  = (ph == 2 || ph == 4) ? 0 : 22;
            stall_pct <= (ph == 2) ? 0 : 22;
            // long receiver hold-off while samples keep coming back to back
            if (ph == 4) holdoff_req <= 1'b1;
            fed = 0;
            while (fed < ITEMS_TOTAL / NUM_PHASES) begin
                it = rand_item();
                if (ph == 4 && fed < PRESS_ITEMS) it.req = REQ_SAMPLE;
                if (ph == 4 && fed == PRESS_ITEMS) idle_pct = 22;
                feed_item(it, 1'b0, '0, took);
                if (took) fed++;
            end
        end

        i_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_px.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
